[hw/rtl/jsu_pkg.sv]
package jsu_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
  localparam logic [2:0] ERR_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_HEX      = 3'd3;
  localparam logic [2:0] ERR_LOW_SUR  = 3'd4;
  localparam logic [2:0] ERR_CONTROL  = 3'd5;
  localparam logic [2:0] ERR_UNTERM   = 3'd6;

  // one queued job: a code point (or raw byte) and its byte count less one
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [20:0] cp;
    logic [1:0]  nb;
  } job_t;

endpackage

[hw/rtl/jsu_front.sv]
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          command,
  input  logic [7:0]    in_byte,
  output logic          push,
  output jsu_pkg::job_t job
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BODY   = 3'd1;
  localparam logic [2:0] PH_ESC    = 3'd2;
  localparam logic [2:0] PH_HEX1   = 3'd3;
  localparam logic [2:0] PH_SUR_BS = 3'd4;
  localparam logic [2:0] PH_SUR_U  = 3'd5;
  localparam logic [2:0] PH_HEX2   = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [9:0]  high_surrogate, high_surrogate_next;

  logic        hv;
  logic [3:0]  h;
  logic [15:0] acc_new;

  always_comb begin
    hv = 1'b1;
    h  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      h = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      h = in_byte[3:0] + 4'd9;
    end else begin
      hv = 1'b0;
    end
  end

  assign acc_new = {hex_accum[11:0], h};

  function automatic logic [1:0] nb_of(input logic [15:0] v);
    if (v < 16'h0080)      nb_of = 2'd0;
    else if (v < 16'h0800) nb_of = 2'd1;
    else                   nb_of = 2'd2;
  endfunction

  always_comb begin
    phase_next          = phase;
    hex_accum_next      = hex_accum;
    hex_count_next      = hex_count;
    high_surrogate_next = high_surrogate;
    push                = 1'b0;
    job.kind            = jsu_pkg::KIND_DATA;
    job.err             = jsu_pkg::ERR_NONE;
    job.cp              = '0;
    job.nb              = 2'd0;
    if (accept) begin
      if (command) begin
        if (phase != PH_IDLE) begin
          push       = 1'b1;
          job.kind   = jsu_pkg::KIND_ERROR;
          job.err    = jsu_pkg::ERR_UNTERM;
          phase_next = PH_IDLE;
        end
      end else begin
        case (phase)
          PH_BODY: begin
            if (in_byte == 8'h22) begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_CLOSE;
              phase_next = PH_IDLE;
            end else if (in_byte == 8'h5C) begin
              phase_next = PH_ESC;
            end else if (in_byte < 8'h20) begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_ERROR;
              job.err    = jsu_pkg::ERR_CONTROL;
              phase_next = PH_IDLE;
            end else begin
              push   = 1'b1;
              job.cp = {13'd0, in_byte};
            end
          end
          PH_ESC: begin
            phase_next = PH_BODY;
            push       = 1'b1;
            case (in_byte)
              8'h22:   job.cp = 21'h22;
              8'h5C:   job.cp = 21'h5C;
              8'h2F:   job.cp = 21'h2F;
              8'h62:   job.cp = 21'h08;
              8'h66:   job.cp = 21'h0C;
              8'h6E:   job.cp = 21'h0A;
              8'h72:   job.cp = 21'h0D;
              8'h74:   job.cp = 21'h09;
              8'h75: begin
                push           = 1'b0;
                phase_next     = PH_HEX1;
                hex_accum_next = '0;
                hex_count_next = '0;
              end
              default: begin
                job.kind   = jsu_pkg::KIND_ERROR;
                job.err    = jsu_pkg::ERR_ESCAPE;
                phase_next = PH_IDLE;
              end
            endcase
          end
          PH_HEX1, PH_HEX2: begin
            if (!hv) begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_ERROR;
              job.err    = jsu_pkg::ERR_HEX;
              phase_next = PH_IDLE;
            end else begin
              hex_accum_next = acc_new;
              if (hex_count != 2'd3) begin
                hex_count_next = hex_count + 2'd1;
              end else begin
                hex_count_next = '0;
                if (phase == PH_HEX1) begin
                  if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                    high_surrogate_next = acc_new[9:0];
                    phase_next          = PH_SUR_BS;
                  end else begin
                    push       = 1'b1;
                    job.cp     = {5'd0, acc_new};
                    job.nb     = nb_of(acc_new);
                    phase_next = PH_BODY;
                  end
                end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                  push       = 1'b1;
                  job.kind   = jsu_pkg::KIND_ERROR;
                  job.err    = jsu_pkg::ERR_LOW_SUR;
                  phase_next = PH_IDLE;
                end else begin
                  push       = 1'b1;
                  job.cp     = 21'h10000 + {1'b0, high_surrogate, acc_new[9:0]};
                  job.nb     = 2'd3;
                  phase_next = PH_BODY;
                end
              end
            end
          end
          PH_SUR_BS: begin
            if (in_byte == 8'h5C) begin
              phase_next = PH_SUR_U;
            end else begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_ERROR;
              job.err    = jsu_pkg::ERR_LOW_SUR;
              phase_next = PH_IDLE;
            end
          end
          PH_SUR_U: begin
            if (in_byte == 8'h75) begin
              phase_next     = PH_HEX2;
              hex_accum_next = '0;
              hex_count_next = '0;
            end else begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_ERROR;
              job.err    = jsu_pkg::ERR_LOW_SUR;
              phase_next = PH_IDLE;
            end
          end
          default: begin
            if (in_byte == 8'h22) begin
              phase_next = PH_BODY;
            end else begin
              push       = 1'b1;
              job.kind   = jsu_pkg::KIND_ERROR;
              job.err    = jsu_pkg::ERR_NO_QUOTE;
              phase_next = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      hex_accum      <= '0;
      hex_count      <= '0;
      high_surrogate <= '0;
    end else begin
      phase          <= phase_next;
      hex_accum      <= hex_accum_next;
      hex_count      <= hex_count_next;
      high_surrogate <= high_surrogate_next;
    end
  end

endmodule

[hw/rtl/jsu_fifo.sv]
module jsu_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::job_t head
);

  jsu_pkg::job_t                   mem [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::CNT_W-1:0] count;

  assign full       = count == jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/jsu_back.sv]
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jsu_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [2:0]    error_code,
  output logic          last
);

  logic [1:0] idx;
  logic [1:0] j;
  logic       load;
  logic       fin;
  logic [7:0] b;

  assign load = head_valid && (!out_valid || out_ready);
  assign fin  = idx == head.nb;
  assign pop  = load && fin;
  assign j    = head.nb - idx;

  // lead byte by length, continuation bytes by position from the end
  always_comb begin
    if (idx == 2'd0) begin
      case (head.nb)
        2'd0:    b = head.cp[7:0];
        2'd1:    b = {3'b110, head.cp[10:6]};
        2'd2:    b = {4'b1110, head.cp[15:12]};
        default: b = {5'b11110, head.cp[20:18]};
      endcase
    end else begin
      case (j)
        2'd0:    b = {2'b10, head.cp[5:0]};
        2'd1:    b = {2'b10, head.cp[11:6]};
        default: b = {2'b10, head.cp[17:12]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load)           idx <= fin ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= b;
      kind       <= head.kind;
      error_code <= head.err;
      last       <= fin;
    end
  end

endmodule

[hw/rtl/json_string_unescape_utf8.sv]
// Decoded jobs are queued, and result words are registered from the
// queue head. Throughput: one input word per cycle while in_ready is high; one
// result word per cycle while out_ready is high (k words for a k-byte \u).
// A 4-entry job queue separates the decode front end from the output stage.
// Reset (rst, synchronous): decoder waits for an opening quote, queue empty.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [2:0] error_code,
  output logic       last
);

  logic          full;
  logic          push;
  logic          pop;
  logic          head_valid;
  jsu_pkg::job_t wr_job;
  jsu_pkg::job_t head;

  assign in_ready = !full;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_valid && in_ready),
    .command (command),
    .in_byte (in_byte),
    .push    (push),
    .job     (wr_job)
  );

  jsu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (wr_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

[hw/rtl/jsu_checker.sv]
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic [2:0] error_code,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) &&
      $stable(error_code) && $stable(last))
    else $error("result word changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != jsu_pkg::KIND_DATA |-> last && out_byte == 8'd0)
    else $error("close or error word not final or carries a byte");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == jsu_pkg::KIND_ERROR) == (error_code != jsu_pkg::ERR_NONE))
    else $error("error code does not match word kind");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .kind       (kind),
  .error_code (error_code),
  .last       (last)
);
